// ===== rtl/pfba_pkg.sv =====
`default_nettype none

package pfba_pkg;

   localparam int MAX_REGIONS  = 16;
   localparam int PAGE_SHIFT   = 12;
   localparam int REGION_IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int COUNT_W      = $clog2(MAX_REGIONS + 1);
   localparam int CSR_INDEX_W  = 8;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FRAME   = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXCLUDED_START = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_EXCLUDED_END   = CSR_INDEX_W'(1);

   // controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
      logic read;
      logic chunk;
      logic place;
      logic window;
      logic fix;
      logic number;
      logic next_region;
      logic no_frame;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic walk_ok;
      logic place_skip;
      logic in_window;
      logic fix_skip;
      logic last_region;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/pfba_ctrl.sv =====
`default_nettype none

module pfba_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  pfba_pkg::dp_stat_type     stat,
   output pfba_pkg::dp_cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_READ   = 9'b000000100,
      S_CHUNK  = 9'b000001000,
      S_PLACE  = 9'b000010000,
      S_WINDOW = 9'b000100000,
      S_FIX    = 9'b001000000,
      S_NUMBER = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_alloc && stat.walk_ok) begin
               state_in = S_READ;
            end else begin
               cmd.no_frame = stat.is_alloc;
               state_in     = S_FINISH;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHUNK;
         end
         S_CHUNK: begin
            cmd.chunk = 1'b1;
            state_in  = S_PLACE;
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            if (!stat.place_skip) begin
               state_in = S_WINDOW;
            end else if (stat.last_region) begin
               cmd.no_frame = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.next_region = 1'b1;
               state_in        = S_READ;
            end
         end
         S_WINDOW: begin
            cmd.window = 1'b1;
            state_in   = stat.in_window ? S_FIX : S_NUMBER;
         end
         S_FIX: begin
            cmd.fix = 1'b1;
            if (!stat.fix_skip) begin
               state_in = S_NUMBER;
            end else if (stat.last_region) begin
               cmd.no_frame = 1'b1;
               state_in     = S_FINISH;
            end else begin
               cmd.next_region = 1'b1;
               state_in        = S_READ;
            end
         end
         S_NUMBER: begin
            cmd.number = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pfba_dp.sv =====
`default_nettype none

module pfba_dp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  pfba_pkg::dp_cmd_type                      cmd,
   output pfba_pkg::dp_stat_type                     stat,
   input  wire logic [1:0]                           req_cmd,
   input  wire logic [63:0]                          req_region_base,
   input  wire logic [63:0]                          req_region_length,
   input  wire logic                                 req_region_reserved,
   input  wire logic                                 csr_wr,
   input  wire logic [pfba_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                          csr_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic [31:0]                               rsp_frame_number,
   output logic [63:0]                               rsp_frame_address
);

   localparam int IDX_W = pfba_pkg::REGION_IDX_W;
   localparam int CNT_W = pfba_pkg::COUNT_W;

   // region table
   logic [63:0] base_mem [pfba_pkg::MAX_REGIONS];
   logic [63:0] len_mem  [pfba_pkg::MAX_REGIONS];
   logic        flag_mem [pfba_pkg::MAX_REGIONS];

   pfba_pkg::cmd_type cmd_ff;
   logic [63:0] base_ff, len_ff;
   logic        resv_ff;

   logic [CNT_W-1:0] count_ff;
   logic [31:0]      next_frame_ff;
   logic [31:0]      xs_ff, xe_ff;
   logic             rsp_valid_ff;

   logic [IDX_W-1:0] r_ff;
   logic [63:0]      rd_base_ff, rd_len_ff;
   logic             rd_flag_ff;
   logic [63:0]      first_ff, start_ff, k_ff, m_ff, a_ff;

   logic [1:0]  res_status_ff;
   logic [31:0] res_num_ff;
   logic [63:0] res_addr_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_num_ff;
   logic [63:0] rsp_addr_ff;

   logic        table_full, mem_wr;
   logic [63:0] room, len_cut, m_in, want, k_in, a_place, a_fix, k_adj, num;
   logic        in_window;

   assign table_full = (count_ff >= CNT_W'(pfba_pkg::MAX_REGIONS));
   assign mem_wr     = cmd.exec && (cmd_ff == pfba_pkg::CMD_LOAD) && !table_full;

   // index of the last chunk, with the region cut off at the top of memory
   assign room    = 64'd0 - rd_base_ff;
   assign len_cut = ((rd_base_ff != 64'd0) && (rd_len_ff > room)) ? room : rd_len_ff;
   assign m_in    = (len_cut == 64'd0) ? 64'd0 : ((len_cut - 64'd1) >> pfba_pkg::PAGE_SHIFT);

   assign want = {32'd0, next_frame_ff};
   assign k_in = (want > first_ff) ? (want - first_ff) : 64'd0;

   assign a_place = rd_base_ff + (k_ff << pfba_pkg::PAGE_SHIFT);
   assign a_fix   = a_place;

   assign in_window = (xs_ff <= xe_ff) && (a_ff >= {32'd0, xs_ff}) && (a_ff <= {32'd0, xe_ff});
   assign k_adj     = k_ff + ((({32'd0, xe_ff}) - a_ff) >> pfba_pkg::PAGE_SHIFT) + 64'd1;

   assign num = start_ff + k_ff;

   always_comb begin
      stat             = '0;
      stat.is_alloc    = (cmd_ff == pfba_pkg::CMD_ALLOC);
      stat.walk_ok     = (next_frame_ff != 32'd0) && (count_ff != '0);
      stat.place_skip  = rd_flag_ff || (k_ff >= m_ff);
      stat.in_window   = in_window;
      stat.fix_skip    = (k_ff >= m_ff);
      stat.last_region = ({1'b0, r_ff} == (IDX_W + 1)'(count_ff - CNT_W'(1)));
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         base_mem[count_ff[IDX_W-1:0]] <= base_ff;
         len_mem[count_ff[IDX_W-1:0]]  <= len_ff;
         flag_mem[count_ff[IDX_W-1:0]] <= resv_ff;
      end
      if (cmd.read) begin
         rd_base_ff <= base_mem[r_ff];
         rd_len_ff  <= len_mem[r_ff];
         rd_flag_ff <= flag_mem[r_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         next_frame_ff <= 32'd1;
         xs_ff         <= 32'd0;
         xe_ff         <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr && (csr_index == pfba_pkg::CSR_EXCLUDED_START)) begin
            xs_ff <= csr_data;
         end
         if (csr_wr && (csr_index == pfba_pkg::CSR_EXCLUDED_END)) begin
            xe_ff <= csr_data;
         end
         if (mem_wr) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.exec && (cmd_ff == pfba_pkg::CMD_RESTART)) begin
            count_ff      <= '0;
            next_frame_ff <= 32'd1;
         end
         if (cmd.number && (num[63:32] == 32'd0)) begin
            next_frame_ff <= num[31:0] + 32'd1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cmd_ff  <= pfba_pkg::cmd_type'(req_cmd);
         base_ff <= req_region_base;
         len_ff  <= req_region_length;
         resv_ff <= req_region_reserved;
      end
      if (cmd.exec) begin
         r_ff          <= '0;
         first_ff      <= 64'd0;
         res_status_ff <= ((cmd_ff == pfba_pkg::CMD_LOAD) && table_full) ?
                          pfba_pkg::STATUS_TABLE_FULL : pfba_pkg::STATUS_OK;
         res_num_ff    <= 32'd0;
         res_addr_ff   <= 64'd0;
      end
      if (cmd.chunk) begin
         m_ff     <= m_in;
         k_ff     <= k_in;
         start_ff <= first_ff;
      end
      if (cmd.place) begin
         first_ff <= first_ff + m_ff;
         a_ff     <= a_place;
      end
      if (cmd.window && in_window) begin
         k_ff <= k_adj;
      end
      if (cmd.fix) begin
         a_ff <= a_fix;
      end
      if (cmd.next_region) begin
         r_ff <= r_ff + IDX_W'(1);
      end
      if (cmd.no_frame) begin
         res_status_ff <= pfba_pkg::STATUS_NO_FRAME;
         res_num_ff    <= 32'd0;
         res_addr_ff   <= 64'd0;
      end
      if (cmd.number) begin
         if (num[63:32] != 32'd0) begin
            res_status_ff <= pfba_pkg::STATUS_NO_FRAME;
            res_num_ff    <= 32'd0;
            res_addr_ff   <= 64'd0;
         end else begin
            res_status_ff <= pfba_pkg::STATUS_OK;
            res_num_ff    <= num[31:0];
            res_addr_ff   <= a_ff;
         end
      end
      if (cmd.finish) begin
         rsp_status_ff <= res_status_ff;
         rsp_num_ff    <= res_num_ff;
         rsp_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_number  = rsp_num_ff;
   assign rsp_frame_address = rsp_addr_ff;

endmodule

`default_nettype wire

// ===== rtl/page_frame_bump_allocator.sv =====
`default_nettype none

// Page frame bump allocator. Region descriptors are loaded into a 16-entry table
// (cmd 0), frames are handed out in increasing chunk number order (cmd 1), and cmd 2
// empties the table and restarts numbering at 1; every request word answers with
// exactly one response word. An allocate walks the region table, with one table read,
// chunk count and placement per region, then a window check where the chunk is not
// skipped and a fix-up where the frame falls in the excluded window; the frame is
// numbered when one is found. The walk goes through the single read port of the
// region table. One request word is in flight at a time; a finished response sits
// in an output register, so the next request is taken while it waits. Registers 0
// and 1 hold the excluded window; the user must write them only while the block is
// idle, which the block itself does not enforce.
module page_frame_bump_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [63:0]                      req_region_base,
   input  wire logic [63:0]                      req_region_length,
   input  wire logic                             req_region_reserved,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [31:0]                           rsp_frame_number,
   output logic [63:0]                           rsp_frame_address,
   // register write channel
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [pfba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]                      csr_data
);

   pfba_pkg::dp_cmd_type  dp_cmd;
   pfba_pkg::dp_stat_type dp_stat;

   // registers always take a write
   assign csr_ready = 1'b1;

   // sequencer for the table walk
   pfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // region table, walk arithmetic and response register
   pfba_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .stat                (dp_stat),
      .req_cmd             (req_cmd),
      .req_region_base     (req_region_base),
      .req_region_length   (req_region_length),
      .req_region_reserved (req_region_reserved),
      .csr_wr              (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_frame_number    (rsp_frame_number),
      .rsp_frame_address   (rsp_frame_address)
   );

endmodule

`default_nettype wire
